>>> src/tswc_pkg.sv
// Shared types and constants of the thread share workload classifier.
package tswc_pkg;

    localparam int ID_W    = 22;
    localparam int RUN_W   = 64;
    localparam int PCT_W   = 7;
    localparam int CLS_W   = 2;
    localparam int CFG_A_W = 3;
    localparam int ACC_W   = 76;

    // Register indexes
    localparam logic [CFG_A_W-1:0] REG_SINGLE_ENTER = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_SINGLE_EXIT  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_DUAL_ENTER   = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_DUAL_EXIT    = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_DUAL_MIN     = 3'd4;

    // Workload classes
    localparam logic [CLS_W-1:0] CLS_IDLE   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_SINGLE = 2'd1;
    localparam logic [CLS_W-1:0] CLS_DUAL   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_MULTI  = 2'd3;

    localparam logic [7:0]       PCT_SCALE       = 8'd100;
    localparam logic [PCT_W-1:0] DUAL_MIN_RESET  = 7'd30;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [RUN_W-1:0] run;
    } entry_t;

    typedef struct packed {
        logic             start;
        logic [RUN_W:0]   x;
        logic [PCT_W-1:0] t;
        logic [RUN_W-1:0] total;
    } cmp_req_t;

    typedef struct packed {
        logic done;
        logic above;
    } cmp_rsp_t;

endpackage

>>> src/tswc_table.sv
// Two-bank sample table: one write port, one registered read port.
module tswc_table
    import tswc_pkg::*;
#(
    parameter int ADDR_W = 7
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  entry_t            wdata,
    input  logic [ADDR_W-1:0] raddr,
    output entry_t            rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tswc_pct_cmp.sv
// Shift-add unit that judges x*100 >= (t+1)*total, one add or subtract a cycle.
module tswc_pct_cmp
    import tswc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cmp_req_t req,
    output cmp_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             phase_reg, phase_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [7:0]       mul_reg, mul_next;
    logic [ACC_W-1:0] op_reg, op_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             done_reg, done_next;
    logic [RUN_W-1:0] total_reg, total_next;
    logic [7:0]       tp1_reg, tp1_next;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        mul_next   = mul_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        total_next = total_reg;
        tp1_next   = tp1_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            cnt_next   = 4'd7;
            mul_next   = PCT_SCALE;
            op_next    = ACC_W'(req.x);
            acc_next   = '0;
            total_next = req.total;
            tp1_next   = {1'b0, req.t} + 8'd1;
        end
        else if (busy_reg)
        begin
            if (mul_reg[0])
            begin
                acc_next = phase_reg ? acc_reg - op_reg : acc_reg + op_reg;
            end
            op_next  = op_reg << 1;
            mul_next = mul_reg >> 1;
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                if (!phase_reg)
                begin
                    // switch to subtracting (t+1)*total
                    phase_next = 1'b1;
                    cnt_next   = 4'd8;
                    op_next    = ACC_W'(total_reg);
                    mul_next   = tp1_reg;
                end
                else
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        mul_reg   <= mul_next;
        op_reg    <= op_next;
        acc_reg   <= acc_next;
        total_reg <= total_next;
        tp1_reg   <= tp1_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.above = ~acc_reg[ACC_W-1];

endmodule

>>> src/thread_share_workload_classifier_core.sv
// Top level of the thread share workload classifier.
// One input word is taken at a time; in_stall stays high until its work is done. A sample
// searches the previous snapshot's table one entry at a time, a read state and a compare
// state per entry (one memory read port), and stops at the first match or at the end of the
// previous snapshot's samples. A word flagged last adds the class decision: each share test
// runs on a shared shift-add unit, up to four tests, none when the snapshot or the previous
// snapshot is empty or the total is zero; the result is then handed to the output register
// when it is free. Samples beyond MAX_SAMPLES in a snapshot are dropped. The table is not
// cleared after reset; only entries written are ever read.
module thread_share_workload_classifier_core
    import tswc_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               sample_valid,
    input  logic [ID_W-1:0]    thread_id,
    input  logic [RUN_W-1:0]   run_time,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CLS_W-1:0]   workload_class,
    output logic [1:0]         hot_threads,
    output logic [ID_W-1:0]    hot_thread_a,
    output logic [ID_W-1:0]    hot_thread_b,
    input  logic               cfg_we,
    input  logic [CFG_A_W-1:0] cfg_index,
    input  logic [PCT_W-1:0]   cfg_data
);

    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_CLS  = 3'd4;
    localparam logic [2:0] S_GO   = 3'd5;
    localparam logic [2:0] S_WAIT = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [1:0] CHK_SINGLE  = 2'd0;
    localparam logic [1:0] CHK_DUALSUM = 2'd1;
    localparam logic [1:0] CHK_TOPONE  = 2'd2;
    localparam logic [1:0] CHK_TOPTWO  = 2'd3;

    logic [2:0]       state_reg, state_next;
    logic [ID_W-1:0]  tid_reg, tid_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic             last_reg, last_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [RUN_W-1:0] delta_reg, delta_next;
    logic [CW-1:0]    cur_cnt_reg, cur_cnt_next;
    logic [CW-1:0]    prev_cnt_reg, prev_cnt_next;
    logic             bank_reg, bank_next;
    logic [CLS_W-1:0] cls_reg, cls_next;
    logic [CLS_W-1:0] new_cls_reg, new_cls_next;
    logic [RUN_W-1:0] total_reg, total_next;
    logic [RUN_W-1:0] top1_reg, top1_next;
    logic [RUN_W-1:0] top2_reg, top2_next;
    logic [ID_W-1:0]  t1id_reg, t1id_next;
    logic [ID_W-1:0]  t2id_reg, t2id_next;
    logic [1:0]       chk_reg, chk_next;

    logic [PCT_W-1:0] s_enter_reg, s_exit_reg, d_enter_reg, d_exit_reg, d_min_reg;

    logic             out_valid_reg, out_valid_next;
    logic [CLS_W-1:0] out_cls_reg, out_cls_next;
    logic [1:0]       out_hot_reg, out_hot_next;
    logic [ID_W-1:0]  out_a_reg, out_a_next;
    logic [ID_W-1:0]  out_b_reg, out_b_next;

    logic             mem_we;
    logic [AW:0]      mem_waddr;
    logic [AW:0]      mem_raddr;
    entry_t           mem_wdata;
    entry_t           mem_rdata;
    cmp_req_t         creq;
    cmp_rsp_t         crsp;
    logic [RUN_W:0]   top_sum;

    tswc_table #(.ADDR_W(AW + 1)) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tswc_pct_cmp u_cmp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    assign top_sum   = {1'b0, top1_reg} + {1'b0, top2_reg};
    assign mem_raddr = {~bank_reg, idx_reg[AW-1:0]};
    assign mem_waddr = {bank_reg, cur_cnt_reg[AW-1:0]};
    assign mem_wdata = '{id: tid_reg, run: run_reg};
    assign mem_we    = (state_reg == S_UPD);

    // operands of the share test under way
    always_comb
    begin
        creq.start = (state_reg == S_GO);
        creq.total = total_reg;
        creq.x     = {1'b0, top1_reg};
        creq.t     = d_min_reg;
        case (chk_reg)
            CHK_SINGLE:
            begin
                creq.t = (cls_reg == CLS_SINGLE) ? s_exit_reg : s_enter_reg;
            end
            CHK_DUALSUM:
            begin
                creq.x = top_sum;
                creq.t = (cls_reg == CLS_DUAL) ? d_exit_reg : d_enter_reg;
            end
            CHK_TOPONE:
            begin
                creq.x = {1'b0, top1_reg};
            end
            default:
            begin
                creq.x = {1'b0, top2_reg};
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        tid_next       = tid_reg;
        run_next       = run_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        delta_next     = delta_reg;
        cur_cnt_next   = cur_cnt_reg;
        prev_cnt_next  = prev_cnt_reg;
        bank_next      = bank_reg;
        cls_next       = cls_reg;
        new_cls_next   = new_cls_reg;
        total_next     = total_reg;
        top1_next      = top1_reg;
        top2_next      = top2_reg;
        t1id_next      = t1id_reg;
        t2id_next      = t2id_reg;
        chk_next       = chk_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_cls_next   = out_cls_reg;
        out_hot_next   = out_hot_reg;
        out_a_next     = out_a_reg;
        out_b_next     = out_b_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    tid_next   = thread_id;
                    run_next   = run_time;
                    last_next  = last_sample;
                    idx_next   = '0;
                    delta_next = '0;
                    if (sample_valid && (cur_cnt_reg < CW'(MAX_SAMPLES)))
                    begin
                        state_next = S_RD;
                    end
                    else if (last_sample)
                    begin
                        state_next = S_CLS;
                    end
                end
            end
            S_RD:
            begin
                state_next = (idx_reg < prev_cnt_reg) ? S_CMP : S_UPD;
            end
            S_CMP:
            begin
                if (mem_rdata.id == tid_reg)
                begin
                    delta_next = (run_reg >= mem_rdata.run) ? run_reg - mem_rdata.run : '0;
                    state_next = S_UPD;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_RD;
                end
            end
            S_UPD:
            begin
                if (cur_cnt_reg == '0)
                begin
                    top1_next = delta_reg;
                    t1id_next = tid_reg;
                end
                else if (delta_reg > top1_reg)
                begin
                    top2_next = top1_reg;
                    t2id_next = t1id_reg;
                    top1_next = delta_reg;
                    t1id_next = tid_reg;
                end
                else if ((cur_cnt_reg == CW'(1)) || (delta_reg > top2_reg))
                begin
                    top2_next = delta_reg;
                    t2id_next = tid_reg;
                end
                total_next   = total_reg + delta_reg;
                cur_cnt_next = cur_cnt_reg + CW'(1);
                state_next   = last_reg ? S_CLS : S_IDLE;
            end
            S_CLS:
            begin
                chk_next = CHK_SINGLE;
                if ((cur_cnt_reg == '0) || (prev_cnt_reg == '0) || (total_reg == '0))
                begin
                    new_cls_next = CLS_IDLE;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_GO;
                end
            end
            S_GO:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (crsp.done)
                begin
                    state_next = S_OUT;
                    case (chk_reg)
                        CHK_SINGLE:
                        begin
                            if (crsp.above)
                            begin
                                new_cls_next = CLS_SINGLE;
                            end
                            else
                            begin
                                chk_next   = CHK_DUALSUM;
                                state_next = S_GO;
                            end
                        end
                        CHK_DUALSUM, CHK_TOPONE:
                        begin
                            if (crsp.above)
                            begin
                                chk_next   = chk_reg + 2'd1;
                                state_next = S_GO;
                            end
                            else
                            begin
                                new_cls_next = CLS_MULTI;
                            end
                        end
                        default:
                        begin
                            new_cls_next = crsp.above ? CLS_DUAL : CLS_MULTI;
                        end
                    endcase
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_cls_next   = new_cls_reg;
                    out_hot_next   = 2'd0;
                    out_a_next     = '0;
                    out_b_next     = '0;
                    if (new_cls_reg == CLS_SINGLE)
                    begin
                        out_hot_next = 2'd1;
                        out_a_next   = t1id_reg;
                    end
                    else if (new_cls_reg == CLS_DUAL)
                    begin
                        out_hot_next = 2'd2;
                        out_a_next   = t1id_reg;
                        out_b_next   = t2id_reg;
                    end
                    // retire the snapshot and swap banks
                    cls_next      = new_cls_reg;
                    prev_cnt_next = cur_cnt_reg;
                    bank_next     = ~bank_reg;
                    cur_cnt_next  = '0;
                    total_next    = '0;
                    top1_next     = '0;
                    top2_next     = '0;
                    t1id_next     = '0;
                    t2id_next     = '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_cnt_reg   <= '0;
            prev_cnt_reg  <= '0;
            bank_reg      <= 1'b0;
            cls_reg       <= CLS_IDLE;
            total_reg     <= '0;
            top1_reg      <= '0;
            top2_reg      <= '0;
            t1id_reg      <= '0;
            t2id_reg      <= '0;
            out_valid_reg <= 1'b0;
            s_enter_reg   <= '0;
            s_exit_reg    <= '0;
            d_enter_reg   <= '0;
            d_exit_reg    <= '0;
            d_min_reg     <= DUAL_MIN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cur_cnt_reg   <= cur_cnt_next;
            prev_cnt_reg  <= prev_cnt_next;
            bank_reg      <= bank_next;
            cls_reg       <= cls_next;
            total_reg     <= total_next;
            top1_reg      <= top1_next;
            top2_reg      <= top2_next;
            t1id_reg      <= t1id_next;
            t2id_reg      <= t2id_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SINGLE_ENTER: s_enter_reg <= cfg_data;
                    REG_SINGLE_EXIT:  s_exit_reg  <= cfg_data;
                    REG_DUAL_ENTER:   d_enter_reg <= cfg_data;
                    REG_DUAL_EXIT:    d_exit_reg  <= cfg_data;
                    REG_DUAL_MIN:     d_min_reg   <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tid_reg     <= tid_next;
        run_reg     <= run_next;
        last_reg    <= last_next;
        idx_reg     <= idx_next;
        delta_reg   <= delta_next;
        new_cls_reg <= new_cls_next;
        chk_reg     <= chk_next;
        out_cls_reg <= out_cls_next;
        out_hot_reg <= out_hot_next;
        out_a_reg   <= out_a_next;
        out_b_reg   <= out_b_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign workload_class = out_cls_reg;
    assign hot_threads    = out_hot_reg;
    assign hot_thread_a   = out_a_reg;
    assign hot_thread_b   = out_b_reg;

endmodule

>>> tb/sv/testbench.sv
// Testbench for the thread share workload classifier: directed and random snapshots.
module testbench;
    import tswc_pkg::*;

    localparam int MAXS = 64;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               sample_valid;
    logic [ID_W-1:0]    thread_id;
    logic [RUN_W-1:0]   run_time;
    logic               last_sample;
    logic               out_valid;
    logic               out_stall;
    logic [CLS_W-1:0]   workload_class;
    logic [1:0]         hot_threads;
    logic [ID_W-1:0]    hot_thread_a;
    logic [ID_W-1:0]    hot_thread_b;
    logic               cfg_we;
    logic [CFG_A_W-1:0] cfg_index;
    logic [PCT_W-1:0]   cfg_data;

    thread_share_workload_classifier_core #(.MAX_SAMPLES(MAXS)) uut (.*);

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [1:0]       hot;
        logic [ID_W-1:0]  ta;
        logic [ID_W-1:0]  tb;
    } verdict_t;

    verdict_t verdict_q[$];
    int errors;
    int samples_sent;
    int verdicts_seen;
    bit quiet_out;

    // predictor state
    logic [PCT_W-1:0] th_single_enter, th_single_exit, th_dual_enter, th_dual_exit, th_dual_min;
    logic [ID_W-1:0]  ids_bank[2][MAXS];
    logic [RUN_W-1:0] runs_bank[2][MAXS];
    bit               bank;
    int               prev_n, cur_n;
    logic [CLS_W-1:0] cls_now;
    logic [RUN_W-1:0] sum_d, top1_d, top2_d;
    logic [ID_W-1:0]  top1_id, top2_id;

    // ids seen in the previous snapshot, to aim random samples at real matches
    logic [ID_W-1:0]  last_ids[$];

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("FAIL thread_share_workload_classifier_core");
        $finish;
    end

    function automatic bit share_above(logic [RUN_W:0] x, logic [PCT_W-1:0] t,
                                       logic [RUN_W-1:0] tot);
        logic [79:0] lhs;
        logic [79:0] rhs;
        begin
            lhs = 80'(x) * 80'd100;
            rhs = 80'(tot) * (80'(t) + 80'd1);
            return lhs >= rhs;
        end
    endfunction

    task automatic predict_word(bit sv, logic [ID_W-1:0] id, logic [RUN_W-1:0] run, bit lst);
        logic [RUN_W-1:0] d;
        logic [RUN_W:0]   pair;
        logic [PCT_W-1:0] sth, dth;
        verdict_t         v;
        begin
            if (sv && cur_n < MAXS)
            begin
                d = '0;
                for (int j = 0; j < prev_n; j++)
                    if (ids_bank[!bank][j] == id)
                    begin
                        if (run >= runs_bank[!bank][j])
                            d = run - runs_bank[!bank][j];
                        break;
                    end
                ids_bank[bank][cur_n] = id;
                runs_bank[bank][cur_n] = run;
                if (cur_n == 0)
                begin
                    top1_d = d;
                    top1_id = id;
                end
                else if (d > top1_d)
                begin
                    top2_d = top1_d;
                    top2_id = top1_id;
                    top1_d = d;
                    top1_id = id;
                end
                else if (cur_n == 1 || d > top2_d)
                begin
                    top2_d = d;
                    top2_id = id;
                end
                sum_d += d;
                cur_n++;
            end
            if (lst)
            begin
                v = '0;
                if (cur_n != 0 && prev_n != 0 && sum_d != 0)
                begin
                    pair = {1'b0, top1_d} + {1'b0, top2_d};
                    sth = (cls_now == CLS_SINGLE) ? th_single_exit : th_single_enter;
                    dth = (cls_now == CLS_DUAL) ? th_dual_exit : th_dual_enter;
                    if (share_above({1'b0, top1_d}, sth, sum_d))
                        v = '{CLS_SINGLE, 2'd1, top1_id, '0};
                    else if (share_above(pair, dth, sum_d)
                             && share_above({1'b0, top1_d}, th_dual_min, sum_d)
                             && share_above({1'b0, top2_d}, th_dual_min, sum_d))
                        v = '{CLS_DUAL, 2'd2, top1_id, top2_id};
                    else
                        v = '{CLS_MULTI, 2'd0, '0, '0};
                end
                cls_now = v.cls;
                last_ids.delete();
                for (int j = 0; j < cur_n; j++)
                    last_ids.push_back(ids_bank[bank][j]);
                prev_n = cur_n;
                bank = !bank;
                cur_n = 0;
                sum_d = '0;
                top1_d = '0;
                top2_d = '0;
                top1_id = '0;
                top2_id = '0;
                verdict_q.push_back(v);
            end
        end
    endtask

    // send one word; the prediction is made when it is accepted; returns at a falling edge
    // with the word still driven, so the caller drives the next word or drops valid
    task automatic send_word(bit sv, logic [ID_W-1:0] id, logic [RUN_W-1:0] run, bit lst,
                             bit calm = 0);
        begin
            if (!calm)
                while ($urandom_range(99) < 13)
                begin
                    in_valid <= 0;
                    sample_valid <= 1'($urandom);
                    thread_id <= ID_W'($urandom);
                    @(negedge clk);
                end
            in_valid <= 1;
            sample_valid <= sv;
            thread_id <= id;
            run_time <= run;
            last_sample <= lst;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            predict_word(sv, id, run, lst);
            if (sv)
                samples_sent++;
            @(negedge clk);
        end
    endtask

    // drop valid, wait for outstanding verdicts, then let the block settle
    task automatic drain();
        begin
            in_valid <= 0;
            while (verdict_q.size() != 0)
                @(negedge clk);
            repeat (300) @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [PCT_W-1:0] val);
        begin
            cfg_we <= 1;
            cfg_index <= idx;
            cfg_data <= val;
            @(negedge clk);
            case (idx)
                REG_SINGLE_ENTER: th_single_enter = val;
                REG_SINGLE_EXIT:  th_single_exit = val;
                REG_DUAL_ENTER:   th_dual_enter = val;
                REG_DUAL_EXIT:    th_dual_exit = val;
                REG_DUAL_MIN:     th_dual_min = val;
                default: ;
            endcase
        end
    endtask

    task automatic set_thresholds(logic [PCT_W-1:0] se, logic [PCT_W-1:0] sx,
                                  logic [PCT_W-1:0] de, logic [PCT_W-1:0] dx,
                                  logic [PCT_W-1:0] dm);
        begin
            drain();
            write_reg(REG_SINGLE_ENTER, se);
            write_reg(REG_SINGLE_EXIT, sx);
            write_reg(REG_DUAL_ENTER, de);
            write_reg(REG_DUAL_EXIT, dx);
            write_reg(REG_DUAL_MIN, dm);
            cfg_we <= 0;
        end
    endtask

    // checker
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            verdicts_seen++;
            if (verdict_q.size() == 0)
            begin
                $error("unexpected verdict class=%0d", workload_class);
                errors++;
            end
            else
            begin
                e = verdict_q.pop_front();
                if (workload_class !== e.cls)
                begin
                    $error("workload_class exp %0d got %0d", e.cls, workload_class);
                    errors++;
                end
                if (hot_threads !== e.hot)
                begin
                    $error("hot_threads exp %0d got %0d", e.hot, hot_threads);
                    errors++;
                end
                if (hot_thread_a !== e.ta)
                begin
                    $error("hot_thread_a exp %0h got %0h", e.ta, hot_thread_a);
                    errors++;
                end
                if (hot_thread_b !== e.tb)
                begin
                    $error("hot_thread_b exp %0h got %0h", e.tb, hot_thread_b);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
        out_stall <= quiet_out ? 1'b0 : ($urandom_range(99) < 13);

    task automatic test_directed();
        begin
            // empty snapshot and no previous snapshot
            send_word(0, 22'd0, 64'd0, 1);
            send_word(0, 22'h155, 64'd5, 0);
            send_word(1, 22'h3FFFFF, 64'd100, 0);
            send_word(1, 22'd0, 64'd0, 1);
            // single: one thread dominates; extremes of run time
            send_word(1, 22'h3FFFFF, 64'd1100, 0);
            send_word(1, 22'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1);
            // decreasing run time, new id
            send_word(1, 22'h3FFFFF, 64'd50, 0);
            send_word(1, 22'd0, 64'd1, 0);
            send_word(1, 22'd7, 64'd9, 1);
            // zero total
            send_word(1, 22'h3FFFFF, 64'd50, 0);
            send_word(1, 22'd0, 64'd1, 1);
            // equal deltas: tie goes to earlier sample
            send_word(1, 22'h3FFFFF, 64'd150, 0);
            send_word(1, 22'd0, 64'd101, 1);
            // total overflow
            send_word(1, 22'h3FFFFF, 64'hFFFF_FFFF_FFFF_FFF0, 0);
            send_word(1, 22'd0, 64'hFFFF_FFFF_FFFF_FFF0, 1);
            // last flag on an empty word after samples
            send_word(1, 22'h3FFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
            send_word(0, 22'h2AAAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1);
        end
    endtask

    task automatic test_capacity();
        begin
            for (int k = 0; k < MAXS + 3; k++)
                send_word(1, 22'(k), 64'(k * 1000), k == MAXS + 2);
            for (int k = 0; k < MAXS + 3; k++)
                send_word(1, 22'(k), 64'(k * 3000 + $urandom_range(500)), k == MAXS + 2);
        end
    endtask

    task automatic random_snapshots(int words);
        int n;
        int left;
        int shape;
        logic [ID_W-1:0]  id;
        logic [RUN_W-1:0] run;
        begin
            left = words;
            while (left > 0)
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(MAXS + 2) : $urandom_range(1, 8);
                shape = $urandom_range(3);
                for (int k = 0; k < n; k++)
                begin
                    if (last_ids.size() != 0 && $urandom_range(9) < 8)
                        id = last_ids[$urandom_range(last_ids.size() - 1)];
                    else
                        id = ID_W'({$urandom, $urandom} >> ($urandom_range(1) ? 0 : 16));
                    case (shape)
                        0: run = {$urandom, $urandom};
                        1: run = 64'(k == 0 ? $urandom_range(100000) : $urandom_range(300))
                                 + 64'(samples_sent) * 1000;
                        2: run = 64'hFFFF_FFFF_0000_0000 + 64'($urandom);
                        default: run = 64'(samples_sent) * 200 + 64'($urandom_range(400));
                    endcase
                    if ($urandom_range(19) == 0)
                        send_word(0, id, run, 0);
                    else
                        send_word(($urandom_range(29) != 0), id, run, k == n - 1);
                    left--;
                end
                if (n == 0)
                    send_word(0, ID_W'($urandom), {$urandom, $urandom}, 1);
            end
        end
    endtask

    task automatic test_random();
        begin
            set_thresholds(7'd60, 7'd40, 7'd70, 7'd50, 7'd30);
            random_snapshots(500);
            set_thresholds(7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
            random_snapshots(200);
            set_thresholds(7'd127, 7'd100, 7'd127, 7'd100, 7'd127);
            random_snapshots(150);
            set_thresholds(7'd100, 7'd99, 7'd99, 7'd100, 7'd49);
            random_snapshots(150);
            set_thresholds(PCT_W'($urandom), PCT_W'($urandom), PCT_W'($urandom),
                           PCT_W'($urandom), PCT_W'($urandom_range(50)));
            quiet_out = 1;
            for (int k = 0; k < 150; k++)
                send_word(1, ID_W'($urandom_range(3)), 64'(k) * 77 + 64'($urandom_range(60)),
                          $urandom_range(3) == 0, 1);
            quiet_out = 0;
            set_thresholds(7'd55, 7'd45, 7'd80, 7'd60, 7'd20);
            random_snapshots(250);
        end
    endtask

    initial
    begin
        errors = 0;
        samples_sent = 0;
        verdicts_seen = 0;
        quiet_out = 0;
        in_valid = 0;
        sample_valid = 0;
        thread_id = '0;
        run_time = '0;
        last_sample = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        th_single_enter = '0;
        th_single_exit = '0;
        th_dual_enter = '0;
        th_dual_exit = '0;
        th_dual_min = DUAL_MIN_RESET;
        bank = 0;
        prev_n = 0;
        cur_n = 0;
        cls_now = CLS_IDLE;
        sum_d = '0;
        top1_d = '0;
        top2_d = '0;
        top1_id = '0;
        top2_id = '0;
        rst_n = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        test_directed();
        test_capacity();
        test_random();
        drain();

        $display("Sent %0d samples; checked %0d class verdicts across threshold sets.",
                 samples_sent, verdicts_seen);
        if (errors == 0 && verdict_q.size() == 0)
            $display("PASS thread_share_workload_classifier_core");
        else
            $display("FAIL thread_share_workload_classifier_core");
        $finish;
    end
endmodule

>>> sim.f
src/tswc_pkg.sv
src/tswc_table.sv
src/tswc_pct_cmp.sv
src/thread_share_workload_classifier_core.sv
tb/sv/testbench.sv
